[design/i2c_char_lcd_nibble_writer_core_defines.svh]
// ----------------------------------------------------------------------------
// LCD nibble writer assertion macros
// Concurrent property wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef I2C_CHAR_LCD_NIBBLE_WRITER_CORE_DEFINES_SVH
`define I2C_CHAR_LCD_NIBBLE_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCDNW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LCDNW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCDNW_ASSERT_SAME(lbl, ante, cons, msg)
`define LCDNW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/lcdnw_pkg.sv]
// ----------------------------------------------------------------------------
// LCD nibble writer package
// Microcode types, symbol codes and the dispatch table.
// ----------------------------------------------------------------------------
`default_nettype none
package lcdnw_pkg;

	localparam int PC_W = 5;

	localparam logic [2:0] FUNC_START  = 3'd0;
	localparam logic [2:0] FUNC_STOP   = 3'd1;
	localparam logic [2:0] FUNC_RAW    = 3'd2;
	localparam logic [2:0] FUNC_NIBBLE = 3'd3;
	localparam logic [2:0] FUNC_CHAR   = 3'd4;
	localparam logic [2:0] FUNC_CMD    = 3'd5;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BIT   = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	localparam logic [PC_W-1:0] EP_START = 5'd0;
	localparam logic [PC_W-1:0] EP_STOP  = 5'd1;
	localparam logic [PC_W-1:0] EP_RAW   = 5'd2;
	localparam logic [PC_W-1:0] EP_LCD   = 5'd5;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_START,
		UOP_STOP,
		UOP_LDRAW,
		UOP_LDNIB,
		UOP_BITS,
		UOP_ACK
	} uop_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_LOOP8,
		BR_IFLCD,
		BR_DONE
	} br_t;

	typedef struct packed {
		uop_t op;
		br_t  br;
		logic nib_lo;
		logic en;
	} ctl_t;

	typedef struct packed {
		logic exec;
		logic term;
	} seq_st_t;

	function automatic logic func_ok(input logic [2:0] f);
		func_ok = (f <= FUNC_CMD);
	endfunction

	function automatic logic [PC_W-1:0] entry(input logic [2:0] f);
		case (f)
			FUNC_START: entry = EP_START;
			FUNC_STOP:  entry = EP_STOP;
			FUNC_RAW:   entry = EP_RAW;
			default:    entry = EP_LCD;
		endcase
	endfunction

endpackage
`default_nettype wire

[design/lcdnw_urom.sv]
// ----------------------------------------------------------------------------
// LCD nibble writer microcode ROM
// One control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none
module lcdnw_urom import lcdnw_pkg::*; (
	input  wire logic [PC_W-1:0] pc,
	output ctl_t                 ctl
);

	function automatic ctl_t cw(input uop_t op, input br_t br, input logic lo,
		input logic en);
		cw = '{op: op, br: br, nib_lo: lo, en: en};
	endfunction

	always_comb begin
		case (pc)
			5'd0:    ctl = cw(UOP_START, BR_DONE,  1'b0, 1'b0);
			5'd1:    ctl = cw(UOP_STOP,  BR_DONE,  1'b0, 1'b0);
			5'd2:    ctl = cw(UOP_LDRAW, BR_NEXT,  1'b0, 1'b0);
			5'd3:    ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd4:    ctl = cw(UOP_ACK,   BR_DONE,  1'b0, 1'b0);
			// high nibble clock
			5'd5:    ctl = cw(UOP_LDNIB, BR_NEXT,  1'b0, 1'b0);
			5'd6:    ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd7:    ctl = cw(UOP_ACK,   BR_NEXT,  1'b0, 1'b0);
			5'd8:    ctl = cw(UOP_LDNIB, BR_NEXT,  1'b0, 1'b1);
			5'd9:    ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd10:   ctl = cw(UOP_ACK,   BR_NEXT,  1'b0, 1'b0);
			5'd11:   ctl = cw(UOP_LDNIB, BR_NEXT,  1'b0, 1'b0);
			5'd12:   ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd13:   ctl = cw(UOP_ACK,   BR_IFLCD, 1'b0, 1'b0);
			// low nibble clock
			5'd14:   ctl = cw(UOP_LDNIB, BR_NEXT,  1'b1, 1'b0);
			5'd15:   ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd16:   ctl = cw(UOP_ACK,   BR_NEXT,  1'b0, 1'b0);
			5'd17:   ctl = cw(UOP_LDNIB, BR_NEXT,  1'b1, 1'b1);
			5'd18:   ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd19:   ctl = cw(UOP_ACK,   BR_NEXT,  1'b0, 1'b0);
			5'd20:   ctl = cw(UOP_LDNIB, BR_NEXT,  1'b1, 1'b0);
			5'd21:   ctl = cw(UOP_BITS,  BR_LOOP8, 1'b0, 1'b0);
			5'd22:   ctl = cw(UOP_ACK,   BR_DONE,  1'b0, 1'b0);
			default: ctl = cw(UOP_NOP,   BR_DONE,  1'b0, 1'b0);
		endcase
	end

endmodule
`default_nettype wire

[design/lcdnw_seq.sv]
// ----------------------------------------------------------------------------
// LCD nibble writer sequencer
// Step counter, bit loop counter and branch resolution.
// ----------------------------------------------------------------------------
`default_nettype none
module lcdnw_seq import lcdnw_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            acc,
	input  wire logic [2:0]      func,
	input  ctl_t                 ctl,
	output logic [PC_W-1:0]      pc,
	output logic                 busy,
	output seq_st_t              st
);

	logic [PC_W-1:0] pc_q;
	logic [2:0]      cnt_q;
	logic            busy_q;
	logic            lcd_q;
	logic            term;
	logic            adv;

	always_comb begin
		term = 1'b0;
		adv  = 1'b0;
		case (ctl.br)
			BR_NEXT:  adv  = 1'b1;
			BR_LOOP8: adv  = (cnt_q == 3'd7);
			BR_IFLCD: begin
				adv  = lcd_q;
				term = !lcd_q;
			end
			default:  term = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			lcd_q  <= 1'b0;
		end else if (acc) begin
			pc_q   <= entry(func);
			cnt_q  <= '0;
			busy_q <= 1'b1;
			lcd_q  <= (func == FUNC_CHAR) || (func == FUNC_CMD);
		end else if (busy_q) begin
			if (term) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				pc_q <= pc_q + 1'b1;
			end
			if (ctl.br == BR_LOOP8) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign pc      = pc_q;
	assign busy    = busy_q;
	assign st.exec = busy_q;
	assign st.term = busy_q && term;

endmodule
`default_nettype wire

[design/lcdnw_dp.sv]
// ----------------------------------------------------------------------------
// LCD nibble writer datapath
// Expander byte shifter and registered symbol outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module lcdnw_dp import lcdnw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       acc,
	input  wire logic [2:0] func,
	input  wire logic [7:0] data,
	input  ctl_t            ctl,
	input  seq_st_t         st,
	output logic            strobe,
	output logic [1:0]      symbol_kind,
	output logic            sda_level,
	output logic            last
);

	logic [7:0] data_q;
	logic       rs_q;
	logic [7:0] byte_q;
	logic       strobe_q;
	logic [1:0] kind_q;
	logic       sda_q;
	logic       last_q;
	logic       emit;
	logic [1:0] kind_d;
	logic       sda_d;
	logic [3:0] nib;

	assign nib = ctl.nib_lo ? data_q[3:0] : data_q[7:4];

	always_comb begin
		emit   = 1'b1;
		kind_d = KIND_BIT;
		sda_d  = 1'b0;
		case (ctl.op)
			UOP_START: kind_d = KIND_START;
			UOP_STOP:  kind_d = KIND_STOP;
			UOP_BITS:  sda_d  = byte_q[7];
			UOP_ACK: begin
				kind_d = KIND_ACK;
				sda_d  = 1'b1;
			end
			default:   emit   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_q <= data;
			rs_q   <= (func == FUNC_NIBBLE) ? data[1] : (func == FUNC_CHAR);
		end
		if (st.exec) begin
			case (ctl.op)
				UOP_LDRAW: byte_q <= data_q;
				UOP_LDNIB: byte_q <= {nib, 1'b1, ctl.en, 1'b0, rs_q};
				UOP_BITS:  byte_q <= {byte_q[6:0], 1'b0};
				default:   byte_q <= byte_q;
			endcase
		end
		kind_q <= kind_d;
		sda_q  <= sda_d;
		last_q <= st.term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= st.exec && emit;
		end
	end

	assign strobe      = strobe_q;
	assign symbol_kind = kind_q;
	assign sda_level   = sda_q;
	assign last        = strobe_q && last_q;

endmodule
`default_nettype wire

[design/i2c_char_lcd_nibble_writer_core.sv]
// ----------------------------------------------------------------------------
// I2C character LCD nibble writer
// Turns LCD requests into a stream of I2C bus symbols.
// ----------------------------------------------------------------------------
// A request word (func, data) is taken at a clock edge with start high and
// busy low. func 0 start, 1 stop, 2 raw byte, 3 one enable-clock cycle,
// 4 data character, 5 command byte; 6 and 7 are dropped with no symbols.
// Each bus symbol appears for one cycle with strobe high; last marks the
// final symbol of the request. The receiver cannot stall the output.
// A microcoded program runs one control word per cycle: a load step emits
// nothing, then a byte goes out as 8 bits and an ack. An enable cycle
// sends three expander bytes (enable low, high, low); a character or command
// sends two enable cycles. The first symbol passes the step counter, then the
// output registers; requests other than start and stop run a load step first.
// Busy drops at the edge that registers the last symbol, so the next request
// may be accepted while that symbol is still on the outputs.
// Reset clears the sequencer and the strobe; no request is pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_char_lcd_nibble_writer_core_defines.svh"
module i2c_char_lcd_nibble_writer_core import lcdnw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] func,
	input  wire logic [7:0] data,
	output logic            strobe,
	output logic [1:0]      symbol_kind,
	output logic            sda_level,
	output logic            last
);

	logic            acc;
	logic [PC_W-1:0] pc;
	ctl_t            ctl;
	seq_st_t         st;

	assign acc = start && !busy && func_ok(func);

	lcdnw_urom u_urom (
		.pc  (pc),
		.ctl (ctl)
	);

	lcdnw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.func   (func),
		.ctl    (ctl),
		.pc     (pc),
		.busy   (busy),
		.st     (st)
	);

	lcdnw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.func        (func),
		.data        (data),
		.ctl         (ctl),
		.st          (st),
		.strobe      (strobe),
		.symbol_kind (symbol_kind),
		.sda_level   (sda_level),
		.last        (last)
	);

	`LCDNW_ASSERT_NEXT(a_no_strobe_idle, !busy, !strobe, "symbol without active request")
	`LCDNW_ASSERT_SAME(a_last_idle, strobe && last, !busy, "busy after last symbol")
	`LCDNW_ASSERT_SAME(a_cond_last, strobe && (symbol_kind == KIND_START || symbol_kind == KIND_STOP), last, "start/stop not last")
	`LCDNW_ASSERT_SAME(a_ack_high, strobe && symbol_kind == KIND_ACK, sda_level, "ack slot SDA low")

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD nibble writer testbench
// Sends request words (start, stop, raw byte, enable cycle, character,
// command, dropped codes) and checks every emitted bus symbol, in order,
// against a bit-level symbol predictor. A directed table comes first, then
// random start / LCD ops / stop sequences mixed with noise words.
// ----------------------------------------------------------------------------
module tb;
	import lcdnw_pkg::*;

	localparam logic [7:0] NIB_MASK  = 8'hF0;
	localparam logic [7:0] LOW_MASK  = 8'h0F;
	localparam logic [7:0] RS_SEL    = 8'h02;
	localparam logic [7:0] EXP_BL    = 8'h08;
	localparam logic [7:0] EXP_BL_EN = 8'h0C;
	localparam logic [7:0] POS_CMD   = 8'h80;
	localparam logic [7:0] CLR_CMD   = 8'h01;
	localparam logic [7:0] HOME_CMD  = 8'h02;
	localparam logic [2:0] FUNC_BAD6 = 3'd6;
	localparam logic [2:0] FUNC_BAD7 = 3'd7;
	localparam int         N_DIR     = 22;
	localparam int         N_RAND    = 288;

	typedef struct packed {
		logic [1:0] kind;
		logic       sda;
		logic       last;
	} bus_sym_t;

	typedef struct packed {
		logic [2:0] f;
		logic [7:0] d;
		logic       typed;
		logic       n_typed;
		bus_sym_t   sym;
	} req_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] func;
	logic [7:0] data;
	logic       strobe;
	logic [1:0] symbol_kind;
	logic       sda_level;
	logic       last;

	bus_sym_t expected_symbols[$];
	req_row_t dir_rows [N_DIR];
	int       errors;
	int       item_no;

	i2c_char_lcd_nibble_writer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.data(data),
		.strobe(strobe),
		.symbol_kind(symbol_kind),
		.sda_level(sda_level),
		.last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic push_sym(input logic [1:0] kind, input logic sda);
		bus_sym_t s;
		s.kind = kind;
		s.sda  = sda;
		s.last = 1'b0;
		expected_symbols.push_back(s);
	endtask

	task automatic push_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--) push_sym(KIND_BIT, b[i]);
		push_sym(KIND_ACK, 1'b1);
	endtask

	task automatic push_enable_cycle(input logic [7:0] v);
		logic [7:0] base;
		base = (v & NIB_MASK) | ((v & RS_SEL) >> 1);
		push_byte(base | EXP_BL);
		push_byte(base | EXP_BL_EN);
		push_byte(base | EXP_BL);
	endtask

	task automatic push_lcd_byte(input logic [7:0] b, input logic [7:0] rs);
		push_enable_cycle((b & NIB_MASK) | rs);
		push_enable_cycle(((b & LOW_MASK) << 4) | rs);
	endtask

	task automatic predict_symbols(input logic [2:0] f, input logic [7:0] d);
		int n0;
		n0 = expected_symbols.size();
		case (f)
			FUNC_START:  push_sym(KIND_START, 1'b0);
			FUNC_STOP:   push_sym(KIND_STOP, 1'b0);
			FUNC_RAW:    push_byte(d);
			FUNC_NIBBLE: push_enable_cycle(d);
			FUNC_CHAR:   push_lcd_byte(d, RS_SEL);
			FUNC_CMD:    push_lcd_byte(d, 8'h00);
			default:     ;
		endcase
		if (expected_symbols.size() > n0)
			expected_symbols[expected_symbols.size() - 1].last = 1'b1;
	endtask

	task automatic send_word(input req_row_t row);
		@(negedge clk);
		if ((item_no < 120 || item_no >= 200) && $urandom_range(0, 99) < 18) begin
			start = 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
		start = 1'b1;
		func  = row.f;
		data  = row.d;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		if (row.typed) begin
			if (row.n_typed) expected_symbols.push_back(row.sym);
		end else begin
			predict_symbols(row.f, row.d);
		end
		item_no++;
	endtask

	function automatic req_row_t plain_row(input logic [2:0] f, input logic [7:0] d);
		req_row_t r;
		r = '0;
		r.f = f;
		r.d = d;
		return r;
	endfunction

	function automatic logic [2:0] pick_lcd_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return FUNC_CHAR;
		if (r < 75) return FUNC_CMD;
		if (r < 90) return FUNC_NIBBLE;
		return FUNC_RAW;
	endfunction

	always @(posedge clk) begin
		bus_sym_t want;
		if (arst_n && strobe === 1'b1) begin
			if (expected_symbols.size() == 0) begin
				$error("unexpected symbol: symbol_kind %0d sda_level %0b last %0b",
					symbol_kind, sda_level, last);
				errors++;
			end else begin
				want = expected_symbols.pop_front();
				if (symbol_kind !== want.kind) begin
					$error("symbol_kind: expected %0d, got %0d", want.kind, symbol_kind);
					errors++;
				end
				if (sda_level !== want.sda) begin
					$error("sda_level: expected %0b, got %0b", want.sda, sda_level);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int sent;
		int n_ops;
		logic [2:0] f;
		errors  = 0;
		item_no = 0;
		sent    = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		func    = FUNC_START;
		data    = 8'h00;

		// typed rows: start, stop and dropped codes; others go through the predictor
		dir_rows = '{
			'{FUNC_START,  8'h00, 1'b1, 1'b1, '{KIND_START, 1'b0, 1'b1}},
			'{FUNC_STOP,   8'hFF, 1'b1, 1'b1, '{KIND_STOP,  1'b0, 1'b1}},
			'{FUNC_RAW,    8'h00, 1'b0, 1'b0, '0},
			'{FUNC_RAW,    8'hFF, 1'b0, 1'b0, '0},
			'{FUNC_RAW,    8'hA5, 1'b0, 1'b0, '0},
			'{FUNC_NIBBLE, 8'h00, 1'b0, 1'b0, '0},
			'{FUNC_NIBBLE, 8'hF2, 1'b0, 1'b0, '0},
			'{FUNC_NIBBLE, 8'hF0, 1'b0, 1'b0, '0},
			'{FUNC_NIBBLE, 8'h0D, 1'b0, 1'b0, '0},
			'{FUNC_NIBBLE, 8'hFF, 1'b0, 1'b0, '0},
			'{FUNC_START,  8'hFF, 1'b1, 1'b1, '{KIND_START, 1'b0, 1'b1}},
			'{FUNC_CMD,    CLR_CMD, 1'b0, 1'b0, '0},
			'{FUNC_CMD,    HOME_CMD, 1'b0, 1'b0, '0},
			'{FUNC_CMD,    POS_CMD | 8'h40, 1'b0, 1'b0, '0},
			'{FUNC_CMD,    8'h00, 1'b0, 1'b0, '0},
			'{FUNC_CMD,    8'hFF, 1'b0, 1'b0, '0},
			'{FUNC_CHAR,   8'h41, 1'b0, 1'b0, '0},
			'{FUNC_CHAR,   8'h00, 1'b0, 1'b0, '0},
			'{FUNC_CHAR,   8'hFF, 1'b0, 1'b0, '0},
			'{FUNC_BAD6,   8'hFF, 1'b1, 1'b0, '0},
			'{FUNC_BAD7,   8'h00, 1'b1, 1'b0, '0},
			'{FUNC_STOP,   8'h00, 1'b1, 1'b1, '{KIND_STOP,  1'b0, 1'b1}}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++) send_word(dir_rows[i]);

		// mostly framed transactions, some loose words and dropped codes
		while (sent < N_RAND) begin
			if ($urandom_range(0, 99) < 80) begin
				send_word(plain_row(FUNC_START, 8'($urandom_range(0, 255))));
				n_ops = $urandom_range(1, 6);
				repeat (n_ops) send_word(plain_row(pick_lcd_op(), 8'($urandom_range(0, 255))));
				send_word(plain_row(FUNC_STOP, 8'($urandom_range(0, 255))));
				sent += n_ops + 2;
			end else begin
				f = 3'($urandom_range(0, 7));
				send_word(plain_row(f, 8'($urandom_range(0, 255))));
				sent++;
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (expected_symbols.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
